// ===== hw/rtl/i2cm_pkg.sv =====
// Shared types and constants for the I2C master bit engine.
// No dependencies; imported by every module of the block.
package i2cm_pkg;

	typedef enum logic [2:0] {
		CMD_NONE    = 3'd0,
		CMD_START   = 3'd1,
		CMD_STOP    = 3'd2,
		CMD_WRITE   = 3'd3,
		CMD_READ    = 3'd4,
		CMD_RECOVER = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_LOW_TICKS     = 2'd0,
		CFG_HIGH_TICKS    = 2'd1,
		CFG_RISE_TICKS    = 2'd2,
		CFG_STRETCH_LIMIT = 2'd3
	} cfg_idx_t;

	typedef enum logic [4:0] {
		PH_IDLE    = 5'd0,
		PH_ST_RISE = 5'd1,
		PH_ST_WAIT = 5'd2,
		PH_ST_SDA  = 5'd3,
		PH_ST_SCL  = 5'd4,
		PH_SP_LOW  = 5'd5,
		PH_SP_RISE = 5'd6,
		PH_SP_WAIT = 5'd7,
		PH_SP_END  = 5'd8,
		PH_BT_RISE = 5'd9,
		PH_BT_WAIT = 5'd10,
		PH_BT_HIGH = 5'd11,
		PH_BT_LOW  = 5'd12,
		PH_RC_RISE = 5'd13,
		PH_RC_HIGH = 5'd14,
		PH_RC_LOW  = 5'd15
	} phase_t;

	localparam logic [3:0]  FRAME_BITS   = 4'd9;
	localparam logic [3:0]  DATA_BITS    = 4'd8;
	localparam logic [3:0]  LAST_DATA    = 4'd7;
	localparam logic [15:0] STRETCH_SAT  = 16'hFFFF;
	localparam logic [7:0]  BYTE_MSB     = 8'h80;

	typedef struct packed {
		logic [15:0] low_ticks;
		logic [15:0] high_ticks;
		logic [15:0] rise_ticks;
		logic [15:0] stretch_limit;
	} cfg_t;

	// one bus tick after command decode
	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] write_data;
		logic       ack_to_send;
		logic       sda_in;
		logic       scl_in;
	} tick_t;

	typedef struct packed {
		logic       scl_pull_low;
		logic       sda_pull_low;
		logic       ready_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       ack_seen;
		logic       timed_out;
	} result_t;

endpackage

// ===== hw/rtl/i2cm_front.sv =====
// Front end: input request register and command decode.
// Depends on i2cm_pkg; feeds i2cm_fifo.
module i2cm_front
	import i2cm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] command,
	input  logic [7:0] write_data,
	input  logic       ack_to_send,
	input  logic       sda_in,
	input  logic       scl_in,
	output logic       push_valid,
	input  logic       push_ready,
	output tick_t      push_tick
);

	logic  valid_s1;
	tick_t tick_s1;
	cmd_t  cmd_dec;

	// codes 6 and 7 mean nothing and are carried as an empty tick
	always_comb begin
		unique case (command)
			CMD_START:   cmd_dec = CMD_START;
			CMD_STOP:    cmd_dec = CMD_STOP;
			CMD_WRITE:   cmd_dec = CMD_WRITE;
			CMD_READ:    cmd_dec = CMD_READ;
			CMD_RECOVER: cmd_dec = CMD_RECOVER;
			default:     cmd_dec = CMD_NONE;
		endcase
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_tick  = tick_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			tick_s1.cmd         <= cmd_dec;
			tick_s1.write_data  <= write_data;
			tick_s1.ack_to_send <= ack_to_send;
			tick_s1.sda_in      <= sda_in;
			tick_s1.scl_in      <= scl_in;
		end
	end

endmodule

// ===== hw/rtl/i2cm_fifo.sv =====
// Two-entry request queue between decode and the bus sequencer.
// Depends on i2cm_pkg for the tick type.
module i2cm_fifo
	import i2cm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  tick_t push_tick,
	output logic  pop_valid,
	input  logic  pop_ready,
	output tick_t pop_tick
);

	tick_t       mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push;
	logic        pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_tick   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)      count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_tick;
	end

endmodule

// ===== hw/rtl/i2cm_seq.sv =====
// Back end: bus sequencer stepping once per queued tick, plus result register.
// Depends on i2cm_pkg; fed by i2cm_fifo.
module i2cm_seq
	import i2cm_pkg::*;
#(
	parameter int DELAY_BITS = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    pop_valid,
	output logic    pop_ready,
	input  tick_t   tick,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t res
);

	localparam logic [32:0] DELAY_MAX = (33'd1 << DELAY_BITS) - 33'd1;

	function automatic logic [DELAY_BITS-1:0] sat_delay(input logic [15:0] t);
		logic [32:0] ext;
		logic [32:0] v;
		ext = {17'd0, t};
		v   = (ext > DELAY_MAX) ? DELAY_MAX : ext;
		return v[DELAY_BITS-1:0];
	endfunction

	phase_t                phase_q, phase_d;
	logic [DELAY_BITS-1:0] delay_q, delay_d;
	logic [15:0]           stretch_q, stretch_d;
	logic [3:0]            bit_q, bit_d;
	logic [7:0]            shift_q, shift_d;
	logic                  scl_q, scl_d;
	logic                  sda_q, sda_d;
	logic                  ack_flag_q, ack_flag_d;
	logic [1:0]            status_q, status_d;
	logic [7:0]            hold_q, hold_d;
	logic                  op_read_q, op_read_d;
	logic                  done_d;
	logic                  out_valid_q;
	result_t               res_q;

	logic                  step;
	logic                  delay_last;
	logic [DELAY_BITS-1:0] delay_dec;
	logic [15:0]           stretch_inc;
	logic [15:0]           limit_eff;
	logic                  stretch_tmo;
	logic [3:0]            bit_inc;
	logic                  more_bits;
	logic                  is_out_cur;
	logic                  is_out_next;
	logic [7:0]            shift_rd;

	assign pop_ready = !out_valid_q || out_ready;
	assign step      = pop_valid && pop_ready;
	assign out_valid = out_valid_q;
	assign res       = res_q;

	assign delay_last  = (delay_q <= DELAY_BITS'(1));
	assign delay_dec   = delay_q - DELAY_BITS'(1);
	assign stretch_inc = (stretch_q != STRETCH_SAT) ? stretch_q + 16'd1 : stretch_q;
	assign limit_eff   = (cfg.stretch_limit != 16'd0) ? cfg.stretch_limit : 16'd1;
	assign stretch_tmo = !tick.scl_in && (stretch_inc >= limit_eff);
	assign bit_inc     = bit_q + 4'd1;
	assign more_bits   = (bit_inc < FRAME_BITS);
	assign is_out_cur  = op_read_q ? (bit_q == DATA_BITS) : (bit_q < DATA_BITS);
	assign is_out_next = op_read_q ? (bit_inc == DATA_BITS) : (bit_inc < DATA_BITS);
	assign shift_rd    = {shift_q[6:0], tick.sda_in};

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_IDLE: begin
				case (tick.cmd)
					CMD_START:                   phase_d = PH_ST_RISE;
					CMD_STOP:                    phase_d = PH_SP_LOW;
					CMD_WRITE, CMD_READ:         phase_d = PH_BT_RISE;
					CMD_RECOVER:                 phase_d = PH_RC_RISE;
					default:                     phase_d = PH_IDLE;
				endcase
			end
			PH_ST_RISE: if (delay_last) phase_d = PH_ST_WAIT;
			PH_ST_WAIT: begin
				if (tick.scl_in)     phase_d = PH_ST_SDA;
				else if (stretch_tmo) phase_d = PH_IDLE;
			end
			PH_ST_SDA:  if (delay_last) phase_d = PH_ST_SCL;
			PH_ST_SCL:  if (delay_last) phase_d = PH_IDLE;
			PH_SP_LOW:  if (delay_last) phase_d = PH_SP_RISE;
			PH_SP_RISE: if (delay_last) phase_d = PH_SP_WAIT;
			PH_SP_WAIT: if (tick.scl_in || stretch_tmo) phase_d = PH_SP_END;
			PH_SP_END:  if (delay_last) phase_d = PH_IDLE;
			PH_BT_RISE: if (delay_last) phase_d = PH_BT_WAIT;
			PH_BT_WAIT: begin
				if (tick.scl_in)     phase_d = PH_BT_HIGH;
				else if (stretch_tmo) phase_d = PH_IDLE;
			end
			PH_BT_HIGH: if (delay_last) phase_d = PH_BT_LOW;
			PH_BT_LOW:  if (delay_last) phase_d = more_bits ? PH_BT_RISE : PH_IDLE;
			PH_RC_RISE: if (delay_last) phase_d = PH_RC_HIGH;
			PH_RC_HIGH: if (delay_last) phase_d = PH_RC_LOW;
			PH_RC_LOW:  if (delay_last) phase_d = more_bits ? PH_RC_RISE : PH_SP_LOW;
			default:    phase_d = PH_IDLE;
		endcase
	end

	// counters, line drives and status
	always_comb begin
		delay_d    = delay_q;
		stretch_d  = stretch_q;
		bit_d      = bit_q;
		shift_d    = shift_q;
		scl_d      = scl_q;
		sda_d      = sda_q;
		ack_flag_d = ack_flag_q;
		status_d   = status_q;
		hold_d     = hold_q;
		op_read_d  = op_read_q;
		done_d     = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (tick.cmd != CMD_NONE) status_d = 2'b00;
				case (tick.cmd)
					CMD_START, CMD_RECOVER: begin
						sda_d   = 1'b0;
						scl_d   = 1'b0;
						bit_d   = 4'd0;
						delay_d = sat_delay(cfg.rise_ticks);
						if (tick.cmd == CMD_START) bit_d = bit_q;
					end
					CMD_STOP: begin
						sda_d   = 1'b1;
						delay_d = sat_delay(cfg.low_ticks);
					end
					CMD_WRITE, CMD_READ: begin
						op_read_d  = (tick.cmd == CMD_READ);
						shift_d    = (tick.cmd == CMD_READ) ? 8'd0 : tick.write_data;
						ack_flag_d = tick.ack_to_send;
						bit_d      = 4'd0;
						// first bit drives data MSB on write, releases on read
						sda_d      = (tick.cmd == CMD_READ) ? 1'b0
						             : ((tick.write_data & BYTE_MSB) == 8'd0);
						scl_d      = 1'b0;
						delay_d    = sat_delay(cfg.rise_ticks);
					end
					default: ;
				endcase
			end
			PH_ST_RISE, PH_SP_RISE, PH_BT_RISE: begin
				if (delay_last) stretch_d = 16'd0;
				else            delay_d   = delay_dec;
			end
			PH_ST_WAIT: begin
				if (tick.scl_in) begin
					sda_d   = 1'b1;
					delay_d = sat_delay(cfg.low_ticks);
				end else begin
					stretch_d = stretch_inc;
					if (stretch_tmo) begin
						status_d[1] = 1'b1;
						done_d      = 1'b1;
					end
				end
			end
			PH_ST_SDA: begin
				if (delay_last) begin
					scl_d   = 1'b1;
					delay_d = sat_delay(cfg.low_ticks);
				end else delay_d = delay_dec;
			end
			PH_ST_SCL, PH_SP_END: begin
				if (delay_last) done_d  = 1'b1;
				else            delay_d = delay_dec;
			end
			PH_SP_LOW: begin
				if (delay_last) begin
					scl_d   = 1'b0;
					delay_d = sat_delay(cfg.rise_ticks);
				end else delay_d = delay_dec;
			end
			PH_SP_WAIT: begin
				// stop carries on after a timeout
				if (!tick.scl_in) stretch_d = stretch_inc;
				if (tick.scl_in || stretch_tmo) begin
					sda_d   = 1'b0;
					delay_d = sat_delay(cfg.rise_ticks);
				end
			end
			PH_BT_WAIT: begin
				if (tick.scl_in) begin
					delay_d = sat_delay(cfg.high_ticks);
				end else begin
					stretch_d = stretch_inc;
					if (stretch_tmo) begin
						status_d[1] = 1'b1;
						done_d      = 1'b1;
					end
				end
			end
			PH_BT_HIGH: begin
				if (delay_last) begin
					if (!is_out_cur) begin
						if (op_read_q) begin
							shift_d = shift_rd;
							if (bit_q == LAST_DATA) hold_d = shift_rd;
						end else if (!tick.sda_in) begin
							status_d[0] = 1'b1;
						end
					end else if (!op_read_q) begin
						shift_d = {shift_q[6:0], 1'b0};
					end
					scl_d   = 1'b1;
					delay_d = sat_delay(cfg.low_ticks);
				end else delay_d = delay_dec;
			end
			PH_BT_LOW: begin
				if (delay_last) begin
					bit_d = bit_inc;
					if (more_bits) begin
						if (is_out_next)
							sda_d = op_read_q ? ack_flag_q : ((shift_q & BYTE_MSB) == 8'd0);
						else
							sda_d = 1'b0;
						scl_d   = 1'b0;
						delay_d = sat_delay(cfg.rise_ticks);
					end else begin
						done_d = 1'b1;
					end
				end else delay_d = delay_dec;
			end
			PH_RC_RISE: begin
				if (delay_last) delay_d = sat_delay(cfg.high_ticks);
				else            delay_d = delay_dec;
			end
			PH_RC_HIGH: begin
				if (delay_last) begin
					scl_d   = 1'b1;
					delay_d = sat_delay(cfg.low_ticks);
				end else delay_d = delay_dec;
			end
			PH_RC_LOW: begin
				if (delay_last) begin
					bit_d = bit_inc;
					if (more_bits) begin
						scl_d   = 1'b0;
						delay_d = sat_delay(cfg.rise_ticks);
					end else begin
						sda_d   = 1'b1;
						delay_d = sat_delay(cfg.low_ticks);
					end
				end else delay_d = delay_dec;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			delay_q     <= '0;
			stretch_q   <= 16'd0;
			bit_q       <= 4'd0;
			shift_q     <= 8'd0;
			scl_q       <= 1'b0;
			sda_q       <= 1'b0;
			ack_flag_q  <= 1'b0;
			status_q    <= 2'b00;
			hold_q      <= 8'd0;
			op_read_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				phase_q    <= phase_d;
				delay_q    <= delay_d;
				stretch_q  <= stretch_d;
				bit_q      <= bit_d;
				shift_q    <= shift_d;
				scl_q      <= scl_d;
				sda_q      <= sda_d;
				ack_flag_q <= ack_flag_d;
				status_q   <= status_d;
				hold_q     <= hold_d;
				op_read_q  <= op_read_d;
			end
			if (step)           out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q.scl_pull_low <= scl_d;
			res_q.sda_pull_low <= sda_d;
			res_q.ready_res    <= (phase_d == PH_IDLE);
			res_q.done_res     <= done_d;
			res_q.read_data    <= hold_d;
			res_q.ack_seen     <= status_d[0];
			res_q.timed_out    <= status_d[1];
		end
	end

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.done_res |-> res_q.ready_res)
		else $error("done reported while sequencer busy");

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= FRAME_BITS)
		else $error("bit counter past frame length");

	a_empty_tick: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_IDLE && tick.cmd == CMD_NONE |=> phase_q == PH_IDLE)
		else $error("idle left without a command");

	a_ack_write_only: assert property (@(posedge clk) disable iff (!arst_n)
		step && status_d[0] && !status_q[0] |-> !op_read_q && phase_q == PH_BT_HIGH)
		else $error("ack flag set outside a write ack slot");
`endif

endmodule

// ===== hw/rtl/i2c_master_bit_engine.sv =====
// Top level of the I2C master bit engine: configuration registers and wiring.
// Depends on i2cm_pkg, i2cm_front, i2cm_fifo and i2cm_seq.
//
// Each input request is one bus tick: it carries the sampled SDA/SCL levels
// and an optional command, and yields exactly one result with the line drives
// and status after that tick. One request is taken every clock cycle while the
// result side accepts; a request's result passes the decode register, the
// two-entry queue and the result register, with the sequencer step that each
// tick needs in front of the result register. Back pressure on the result side
// fills the queue and then drops in_ready. Delay registers are written through
// the cfg channel; the user must write them only while no tick is in flight, as
// the block itself does not enforce this; there is no clearing pass after reset.
module i2c_master_bit_engine
	import i2cm_pkg::*;
#(
	parameter int DELAY_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  command,
	input  logic [7:0]  write_data,
	input  logic        ack_to_send,
	input  logic        sda_in,
	input  logic        scl_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        scl_pull_low,
	output logic        sda_pull_low,
	output logic        ready_res,
	output logic        done_res,
	output logic [7:0]  read_data,
	output logic        ack_seen,
	output logic        timed_out
);

	cfg_t    cfg_q;
	logic    push_valid;
	logic    push_ready;
	tick_t   push_tick;
	logic    pop_valid;
	logic    pop_ready;
	tick_t   pop_tick;
	result_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_ticks     <= 16'd10;
			cfg_q.high_ticks    <= 16'd10;
			cfg_q.rise_ticks    <= 16'd2;
			cfg_q.stretch_limit <= 16'd1000;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LOW_TICKS:     cfg_q.low_ticks     <= cfg_data;
				CFG_HIGH_TICKS:    cfg_q.high_ticks    <= cfg_data;
				CFG_RISE_TICKS:    cfg_q.rise_ticks    <= cfg_data;
				CFG_STRETCH_LIMIT: cfg_q.stretch_limit <= cfg_data;
				default: ;
			endcase
		end
	end

	i2cm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.write_data  (write_data),
		.ack_to_send (ack_to_send),
		.sda_in      (sda_in),
		.scl_in      (scl_in),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_tick   (push_tick)
	);

	i2cm_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_tick  (push_tick),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_tick   (pop_tick)
	);

	i2cm_seq #(
		.DELAY_BITS (DELAY_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.tick      (pop_tick),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign scl_pull_low = res.scl_pull_low;
	assign sda_pull_low = res.sda_pull_low;
	assign ready_res    = res.ready_res;
	assign done_res     = res.done_res;
	assign read_data    = res.read_data;
	assign ack_seen     = res.ack_seen;
	assign timed_out    = res.timed_out;

endmodule
